FILE: hw/rtl/cdrq_pkg.sv
// Shared types, widths and codes for the C-LOOK disk request queue.
`timescale 1ns / 1ps

package cdrq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam int TRACK_W  = 10;
	localparam int SECTOR_W = 8;
	localparam int TAG_W    = 16;
	localparam int ENTRY_W  = TRACK_W + SECTOR_W + TAG_W;

	localparam int S_TDATA_W = ((ENTRY_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((ENTRY_W + CNT_W + 7) / 8) * 8;

	localparam logic KIND_ADD  = 1'b0;
	localparam logic KIND_TAKE = 1'b1;

	typedef enum logic [1:0] {
		ST_ADDED  = 2'd0,
		ST_SERVED = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_FULL   = 2'd3
	} status_t;

	typedef struct packed {
		logic [TAG_W-1:0]    tag;
		logic [SECTOR_W-1:0] sector;
		logic [TRACK_W-1:0]  track;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr;
		logic              entry_we;
		logic [IDX_W-1:0]  entry_waddr;
		entry_t            entry_wdata;
		logic              link_we;
		logic [IDX_W-1:0]  link_waddr;
		logic [IDX_W-1:0]  link_wdata;
	} store_req_t;

endpackage

FILE: hw/rtl/clook_disk_request_queue.sv
// Top level of the C-LOOK disk request queue: control sequencer, free slot stack and result register.
`timescale 1ns / 1ps

// Requests are held as a linked list in C-LOOK service order, in an entry memory and a link
// memory that each have a registered read port. A take (tuser high) pops the head and its
// result passes through S_TAKE and S_EMIT to the output register. An add (tuser low) writes the
// entry, then walks the list from the head one entry per cycle, bounded by the link memory's
// single read port; into an empty queue it goes from S_SLOT to S_EMIT, otherwise through S_HEAD,
// then S_WALK for each further entry read, and S_LINK when it links in ahead of the tail.
// Adds to a full queue and takes from an empty one go straight to S_EMIT.
// A new request is taken only when the previous one is finished, while its result may still
// wait at the output.
module clook_disk_request_queue
	import cdrq_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // track, sector, tag, zero padding
	input  logic                 s_tuser,  // kind
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,  // served_track, served_sector, served_tag, occupancy, zero padding
	output logic [1:0]           m_tuser   // status
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TAKE,
		S_SLOT,
		S_HEAD,
		S_WALK,
		S_LINK,
		S_EMIT
	} state_t;

	state_t                 state_q;
	logic [IDX_W-1:0]       head_q;
	logic [IDX_W-1:0]       tail_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       slot_q;
	logic [IDX_W-1:0]       cur_q;
	logic [IDX_W-1:0]       nxt_q;
	logic [TRACK_W-1:0]     ct_q;
	entry_t                 in_q;
	logic                   fsel_q;
	status_t                res_status_q;
	entry_t                 res_entry_q;
	logic                   out_valid_q;
	logic [M_TDATA_W-1:0]   out_data_q;
	logic [1:0]             out_user_q;

	logic [QUEUE_DEPTH-1:0] fvalid_q;
	logic [IDX_W-1:0]       free_mem [QUEUE_DEPTH];
	logic [IDX_W-1:0]       free_rd_q;

	store_req_t             req;
	entry_t                 rd_entry;
	logic [IDX_W-1:0]       rd_link;

	logic                   accept;
	logic                   out_free;
	logic [IDX_W-1:0]       slot_w;
	logic [IDX_W-1:0]       cnt_idx;
	logic [IDX_W-1:0]       pop_idx;
	logic [TRACK_W-1:0]     nt;
	logic [TRACK_W-1:0]     t;
	logic                   ins;
	entry_t                 s_entry;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;
	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign pop_idx  = cnt_idx - IDX_W'(1);
	assign slot_w   = fsel_q ? free_rd_q : cnt_idx;
	assign nt       = rd_entry.track;
	assign t        = in_q.track;
	assign s_entry  = entry_t'(s_tdata[ENTRY_W-1:0]);

	// The new request links in after the current entry when it closes a run of equal tracks,
	// falls between its neighbours, or belongs just before or after the wrap point.
	assign ins = ((ct_q == t) && (nt != t))
		|| ((ct_q > t) && (nt > t) && (ct_q > nt))
		|| ((ct_q < t) && (nt > t))
		|| ((ct_q < t) && (ct_q > nt));

	always_comb begin
		req             = '0;
		req.entry_waddr = slot_w;
		req.entry_wdata = in_q;
		req.rd_addr     = head_q;
		case (state_q)
			S_IDLE: begin
				req.rd_en = accept && (s_tuser == KIND_TAKE);
			end
			S_SLOT: begin
				req.entry_we = 1'b1;
				req.rd_en    = 1'b1;
			end
			S_HEAD: begin
				if (head_q == tail_q) begin
					req.link_we    = 1'b1;
					req.link_waddr = head_q;
					req.link_wdata = slot_q;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = rd_link;
				end
			end
			S_WALK: begin
				if (ins) begin
					req.link_we    = 1'b1;
					req.link_waddr = slot_q;
					req.link_wdata = nxt_q;
				end else if (nxt_q == tail_q) begin
					req.link_we    = 1'b1;
					req.link_waddr = nxt_q;
					req.link_wdata = slot_q;
				end else begin
					req.rd_en   = 1'b1;
					req.rd_addr = rd_link;
				end
			end
			S_LINK: begin
				req.link_we    = 1'b1;
				req.link_waddr = cur_q;
				req.link_wdata = slot_q;
			end
			default: begin
				req.rd_en = 1'b0;
			end
		endcase
	end

	cdrq_store u_store (
		.clk      (clk),
		.req      (req),
		.rd_entry (rd_entry),
		.rd_link  (rd_link)
	);

	always_ff @(posedge clk) begin
		free_rd_q <= free_mem[cnt_idx];
		if (state_q == S_TAKE) begin
			free_mem[pop_idx] <= head_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fvalid_q <= '0;
		end else if (state_q == S_TAKE) begin
			fvalid_q[pop_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_q <= s_entry;
						if (s_tuser == KIND_TAKE) begin
							if (cnt_q == '0) begin
								res_status_q <= ST_EMPTY;
								res_entry_q  <= '0;
								state_q      <= S_EMIT;
							end else begin
								state_q <= S_TAKE;
							end
						end else begin
							if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								res_status_q <= ST_FULL;
								res_entry_q  <= '0;
								state_q      <= S_EMIT;
							end else begin
								fsel_q  <= fvalid_q[cnt_idx];
								state_q <= S_SLOT;
							end
						end
					end
				end
				S_TAKE: begin
					res_status_q <= ST_SERVED;
					res_entry_q  <= rd_entry;
					head_q       <= rd_link;
					cnt_q        <= cnt_q - CNT_W'(1);
					state_q      <= S_EMIT;
				end
				S_SLOT: begin
					slot_q       <= slot_w;
					res_status_q <= ST_ADDED;
					res_entry_q  <= '0;
					cnt_q        <= cnt_q + CNT_W'(1);
					if (cnt_q == '0) begin
						head_q  <= slot_w;
						tail_q  <= slot_w;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_HEAD;
					end
				end
				S_HEAD: begin
					cur_q <= head_q;
					ct_q  <= rd_entry.track;
					nxt_q <= rd_link;
					if (head_q == tail_q) begin
						tail_q  <= slot_q;
						state_q <= S_EMIT;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					if (ins) begin
						state_q <= S_LINK;
					end else if (nxt_q == tail_q) begin
						tail_q  <= slot_q;
						state_q <= S_EMIT;
					end else begin
						cur_q <= nxt_q;
						ct_q  <= nt;
						nxt_q <= rd_link;
					end
				end
				S_LINK: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_data_q  <= M_TDATA_W'({cnt_q, res_entry_q});
						out_user_q  <= res_status_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

FILE: hw/rtl/cdrq_store.sv
// Entry and link memories of the request queue, one write and one registered read each.
`timescale 1ns / 1ps

module cdrq_store
	import cdrq_pkg::*;
(
	input  logic             clk,
	input  store_req_t       req,
	output entry_t           rd_entry,
	output logic [IDX_W-1:0] rd_link
);

	entry_t           entry_mem [QUEUE_DEPTH];
	logic [IDX_W-1:0] link_mem  [QUEUE_DEPTH];
	entry_t           rd_entry_q;
	logic [IDX_W-1:0] rd_link_q;

	always_ff @(posedge clk) begin
		if (req.entry_we) begin
			entry_mem[req.entry_waddr] <= req.entry_wdata;
		end
		if (req.link_we) begin
			link_mem[req.link_waddr] <= req.link_wdata;
		end
		if (req.rd_en) begin
			rd_entry_q <= entry_mem[req.rd_addr];
			rd_link_q  <= link_mem[req.rd_addr];
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_link  = rd_link_q;

endmodule

FILE: hw/rtl/cdrq_checker.sv
// Port-level checks of the C-LOOK disk request queue and their binding to the top level.
`timescale 1ns / 1ps

module cdrq_checker
	import cdrq_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [1:0]           m_tuser
);

	logic [CNT_W-1:0] occ;

	assign occ = m_tdata[ENTRY_W+CNT_W-1:ENTRY_W];

	// A result that is not taken keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// Only a served request carries request fields.
	a_served_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser != ST_SERVED) |-> m_tdata[ENTRY_W-1:0] == '0)
		else $error("request fields set on a result that served nothing");

	// A take on an empty queue leaves it empty.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_EMPTY) |-> occ == '0)
		else $error("empty status with non-zero occupancy");

	// A dropped add reports a full queue.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_FULL) |-> occ == CNT_W'(QUEUE_DEPTH))
		else $error("full status with occupancy below the depth");

	// An added request leaves at least one entry queued.
	a_added_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_ADDED) |-> occ != '0)
		else $error("added status with an empty queue");

endmodule

bind clook_disk_request_queue cdrq_checker u_cdrq_checker (.*);
